// ===== design/shc_pkg.sv =====
package shc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 15;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ROOM_OFFSET   = 3'd0,
    CFG_DIE_NOMINAL   = 3'd1,
    CFG_HEAT_FACTOR   = 3'd2,
    CFG_HEAT_COMP_CAP = 3'd3,
    CFG_RH_PER_DEGREE = 3'd4,
    CFG_SMOOTH_ALPHA  = 3'd5
  } cfg_idx_e;

  localparam logic signed [10:0] RoomOffsetRst  = -11'sd300;
  localparam logic signed [14:0] DieNominalRst  = 15'sd3000;
  localparam logic        [7:0]  HeatFactorRst  = 8'd64;
  localparam logic        [10:0] HeatCompCapRst = 11'd250;
  localparam logic        [7:0]  RhPerDegreeRst = 8'd72;
  localparam logic        [8:0]  SmoothAlphaRst = 9'd51;

  localparam logic signed [16:0] TempLow  = -17'sd4000;
  localparam logic signed [16:0] TempHigh = 17'sd8500;
  localparam logic signed [16:0] SatLow   = -17'sd16384;
  localparam logic signed [16:0] SatHigh  = 17'sd16383;
  localparam logic signed [22:0] HumMax   = 23'sd10000;
  localparam logic        [8:0]  AlphaOne = 9'd256;

  // Operand pairs of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_HEAT = 2'd0,
    MUL_RH   = 2'd1,
    MUL_OLD  = 2'd2,
    MUL_NEW  = 2'd3
  } mul_op_e;

  typedef struct packed {
    logic    ld_in;
    logic    mul_en;
    mul_op_e mul_op;
    logic    ld_comp;
    logic    ld_temp;
    logic    ld_hum;
    logic    ld_acc;
    logic    ld_avg;
    logic    ld_out;
  } shc_cmd_t;

endpackage

// ===== design/shc_ctrl.sv =====
module shc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              reading_ok_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output shc_pkg::shc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAT_MUL,
    ST_COMP,
    ST_CLAMP,
    ST_RH_MUL,
    ST_HUM,
    ST_OLD_MUL,
    ST_NEW_MUL,
    ST_AVG,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_op = shc_pkg::MUL_HEAT;
    unique case (state_q)
      ST_IDLE: begin
        // A failed reading is taken and dropped without leaving idle.
        if (in_valid_i && reading_ok_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_HEAT_MUL;
        end
      end
      ST_HEAT_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = shc_pkg::MUL_HEAT;
        state_d      = ST_COMP;
      end
      ST_COMP: begin
        cmd_o.ld_comp = 1'b1;
        state_d       = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.ld_temp = 1'b1;
        state_d       = ST_RH_MUL;
      end
      ST_RH_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = shc_pkg::MUL_RH;
        state_d      = ST_HUM;
      end
      ST_HUM: begin
        cmd_o.ld_hum = 1'b1;
        state_d      = ST_OLD_MUL;
      end
      ST_OLD_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = shc_pkg::MUL_OLD;
        state_d      = ST_NEW_MUL;
      end
      ST_NEW_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = shc_pkg::MUL_NEW;
        cmd_o.ld_acc = 1'b1;
        state_d      = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.ld_avg = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Hold the finished result until the output register is free.
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/shc_datapath.sv =====
module shc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [shc_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [shc_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  input  shc_pkg::shc_cmd_t                    cmd_i,
  input  logic signed [14:0]                   raw_temperature_i,
  input  logic        [13:0]                   raw_humidity_i,
  input  logic        [16:0]                   pressure_in_i,
  input  logic signed [14:0]                   die_temperature_i,
  input  logic                                 die_valid_i,
  output logic signed [14:0]                   temperature_out_o,
  output logic        [13:0]                   humidity_out_o,
  output logic        [16:0]                   pressure_out_o,
  output logic        [10:0]                   heat_comp_applied_o
);

  // Configuration registers.
  logic signed [10:0] room_q;
  logic signed [14:0] nom_q;
  logic        [7:0]  hf_q;
  logic        [10:0] cap_q;
  logic        [7:0]  rh_q;
  logic        [8:0]  alpha_q;

  // Item registers.
  logic signed [14:0] rt_q;
  logic        [13:0] hum_q;
  logic        [16:0] press_q;
  logic               dv_q;
  logic signed [15:0] t0_q, t0_d;
  logic signed [16:0] exc_q, exc_d;
  logic signed [32:0] prod_q, prod_d;
  logic signed [32:0] acc_q;
  logic        [10:0] comp_q, comp_d;
  logic signed [14:0] t_q, t_d;
  logic signed [16:0] err_q, err_d;
  logic        [21:0] hs_q, hs_d;

  // Moving average state.
  logic        [21:0] avg_q, avg_d;
  logic               primed_q;

  // Output register.
  logic signed [14:0] temp_out_q;
  logic        [13:0] hum_out_q;
  logic        [16:0] press_out_q;
  logic        [10:0] comp_out_q;

  logic signed [22:0] mul_a;
  logic signed [9:0]  mul_b;
  logic        [8:0]  alpha_eff;
  logic signed [32:0] comp_raw;
  logic signed [32:0] cap_ext;
  logic               exc_pos;
  logic signed [16:0] t0_ext, comp_ext, diff;
  logic signed [16:0] t_clamped;
  logic signed [32:0] adj;
  logic signed [22:0] h_sum;
  logic        [13:0] h_clamped;
  logic signed [32:0] avg_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q  <= shc_pkg::RoomOffsetRst;
      nom_q   <= shc_pkg::DieNominalRst;
      hf_q    <= shc_pkg::HeatFactorRst;
      cap_q   <= shc_pkg::HeatCompCapRst;
      rh_q    <= shc_pkg::RhPerDegreeRst;
      alpha_q <= shc_pkg::SmoothAlphaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        shc_pkg::CFG_ROOM_OFFSET:   room_q  <= cfg_wdata_i[10:0];
        shc_pkg::CFG_DIE_NOMINAL:   nom_q   <= cfg_wdata_i[14:0];
        shc_pkg::CFG_HEAT_FACTOR:   hf_q    <= cfg_wdata_i[7:0];
        shc_pkg::CFG_HEAT_COMP_CAP: cap_q   <= cfg_wdata_i[10:0];
        shc_pkg::CFG_RH_PER_DEGREE: rh_q    <= cfg_wdata_i[7:0];
        shc_pkg::CFG_SMOOTH_ALPHA:  alpha_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  assign t0_d  = 16'(raw_temperature_i) + 16'(room_q);
  assign exc_d = 17'(die_temperature_i) - 17'(nom_q);

  assign alpha_eff = (alpha_q > shc_pkg::AlphaOne) ? shc_pkg::AlphaOne : alpha_q;

  // One multiplier serves the heating term, the humidity error and both
  // halves of the moving average.
  always_comb begin
    case (cmd_i.mul_op)
      shc_pkg::MUL_HEAT: begin
        mul_a = 23'(exc_q);
        mul_b = signed'({2'b00, hf_q});
      end
      shc_pkg::MUL_RH: begin
        mul_a = 23'(err_q);
        mul_b = signed'({2'b00, rh_q});
      end
      shc_pkg::MUL_OLD: begin
        mul_a = signed'({1'b0, avg_q});
        mul_b = signed'({1'b0, shc_pkg::AlphaOne - alpha_eff});
      end
      default: begin
        mul_a = signed'({1'b0, hs_q});
        mul_b = signed'({1'b0, alpha_eff});
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Self-heating term, capped.
  assign comp_raw = prod_q >>> 8;
  assign cap_ext  = signed'({22'd0, cap_q});
  assign exc_pos  = !exc_q[16] && (exc_q != '0);

  always_comb begin
    if (dv_q && exc_pos) begin
      comp_d = (comp_raw > cap_ext) ? cap_q : comp_raw[10:0];
    end else begin
      comp_d = '0;
    end
  end

  // Corrected temperature: range clamp with a die reading, saturation without.
  assign t0_ext   = 17'(t0_q);
  assign comp_ext = signed'({6'd0, comp_q});
  assign diff     = t0_ext - comp_ext;

  always_comb begin
    if (dv_q) begin
      if (diff < shc_pkg::TempLow) begin
        t_clamped = shc_pkg::TempLow;
      end else if (diff > shc_pkg::TempHigh) begin
        t_clamped = shc_pkg::TempHigh;
      end else begin
        t_clamped = diff;
      end
    end else begin
      if (diff < shc_pkg::SatLow) begin
        t_clamped = shc_pkg::SatLow;
      end else if (diff > shc_pkg::SatHigh) begin
        t_clamped = shc_pkg::SatHigh;
      end else begin
        t_clamped = diff;
      end
    end
  end

  assign t_d   = t_clamped[14:0];
  assign err_d = 17'(rt_q) - 17'(t_d);

  // Humidity correction; the arithmetic shift floors the product.
  assign adj   = prod_q >>> 4;
  assign h_sum = signed'({9'd0, hum_q}) + adj[22:0];

  always_comb begin
    if (h_sum < 0) begin
      h_clamped = '0;
    end else if (h_sum > shc_pkg::HumMax) begin
      h_clamped = shc_pkg::HumMax[13:0];
    end else begin
      h_clamped = h_sum[13:0];
    end
  end

  assign hs_d    = {h_clamped, 8'd0};
  assign avg_sum = acc_q + prod_q;
  assign avg_d   = avg_sum[29:8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      rt_q    <= raw_temperature_i;
      hum_q   <= raw_humidity_i;
      press_q <= pressure_in_i;
      dv_q    <= die_valid_i;
      t0_q    <= t0_d;
      exc_q   <= exc_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ld_acc) begin
      acc_q <= prod_q;
    end
    if (cmd_i.ld_comp) begin
      comp_q <= comp_d;
    end
    if (cmd_i.ld_temp) begin
      t_q   <= t_d;
      err_q <= err_d;
    end
    if (cmd_i.ld_hum) begin
      hs_q <= hs_d;
    end
    if (cmd_i.ld_out) begin
      temp_out_q  <= t_q;
      hum_out_q   <= avg_q[21:8];
      press_out_q <= press_q;
      comp_out_q  <= comp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      primed_q <= 1'b0;
    end else if (cmd_i.ld_hum && !primed_q) begin
      // The first good sample seeds the average.
      avg_q    <= hs_d;
      primed_q <= 1'b1;
    end else if (cmd_i.ld_avg) begin
      avg_q <= avg_d;
    end
  end

  assign temperature_out_o   = temp_out_q;
  assign humidity_out_o      = hum_out_q;
  assign pressure_out_o      = press_out_q;
  assign heat_comp_applied_o = comp_out_q;

endmodule

// ===== design/sensor_heat_compensation_ema_unit.sv =====
// Each good reading is walked by the controller through the single shared multiplier
// four times; its result is registered once the output register is free, and no new
// reading is taken until the controller is back in idle.
// A failed reading is taken without leaving idle and yields no result.
// Reset is asynchronous and active low; it restores the register defaults
// and clears the humidity average and its primed flag.
module sensor_heat_compensation_ema_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [shc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [shc_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             reading_ok_i,
  input  logic signed [14:0]               raw_temperature_i,
  input  logic        [13:0]               raw_humidity_i,
  input  logic        [16:0]               pressure_in_i,
  input  logic signed [14:0]               die_temperature_i,
  input  logic                             die_valid_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [14:0]               temperature_out_o,
  output logic        [13:0]               humidity_out_o,
  output logic        [16:0]               pressure_out_o,
  output logic        [10:0]               heat_comp_applied_o
);

  shc_pkg::shc_cmd_t cmd;

  shc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .reading_ok_i (reading_ok_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  shc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (cmd),
    .raw_temperature_i   (raw_temperature_i),
    .raw_humidity_i      (raw_humidity_i),
    .pressure_in_i       (pressure_in_i),
    .die_temperature_i   (die_temperature_i),
    .die_valid_i         (die_valid_i),
    .temperature_out_o   (temperature_out_o),
    .humidity_out_o      (humidity_out_o),
    .pressure_out_o      (pressure_out_o),
    .heat_comp_applied_o (heat_comp_applied_o)
  );

endmodule

// ===== design/shc_checker.sv =====
module shc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               reading_ok_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] temperature_out_o,
  input logic        [13:0] humidity_out_o,
  input logic        [16:0] pressure_out_o,
  input logic        [10:0] heat_comp_applied_o
);

  // A good reading keeps the block busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && reading_ok_i) |=> !in_ready_o)
    else $error("input taken again right after a good reading");

  // A dropped reading leaves the block ready at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !reading_ok_i) |=> in_ready_o)
    else $error("failed reading stalled the input");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(temperature_out_o)
      && $stable(humidity_out_o) && $stable(pressure_out_o)
      && $stable(heat_comp_applied_o)))
    else $error("stalled result beat changed");

  // The smoothed humidity never leaves 0..100 %RH.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (humidity_out_o <= 14'd10000))
    else $error("humidity result above full scale");

endmodule

bind sensor_heat_compensation_ema_unit shc_checker u_shc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .reading_ok_i        (reading_ok_i),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .temperature_out_o   (temperature_out_o),
  .humidity_out_o      (humidity_out_o),
  .pressure_out_o      (pressure_out_o),
  .heat_comp_applied_o (heat_comp_applied_o)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int DrainCycles      = 12;
  localparam int CycleLimit       = 400000;
  localparam int RandomPhases     = 8;
  localparam int ReadingsPerPhase = 55;
  localparam int NumRegs          = 6;
  localparam int MaxReports       = 10;

  typedef logic [shc_pkg::CfgIdxWidth-1:0]  cfg_idx_t;
  typedef logic [shc_pkg::CfgDataWidth-1:0] cfg_data_t;

  // Indexes past the register map; writes to them must be ignored.
  localparam cfg_idx_t CfgIdxUnmapped = 3'd6;
  localparam cfg_idx_t CfgIdxTop      = 3'd7;

  localparam longint ClampLow  = -4000;
  localparam longint ClampHigh = 8500;
  localparam longint SatFloor  = -16384;
  localparam longint SatCeil   = 16383;
  localparam longint HumCeil   = 10000;
  localparam longint AlphaFull = 256;

  typedef struct {
    logic               ok;
    logic signed [14:0] amb_temp;
    logic        [13:0] raw_hum;
    logic        [16:0] pres;
    logic signed [14:0] die_temp;
    logic               die_valid;
  } reading_t;

  typedef struct {
    logic signed [14:0] temp;
    logic        [13:0] hum;
    logic        [16:0] pres;
    logic        [10:0] heat;
  } comp_result_t;

  typedef enum logic {
    ROW_READING,
    ROW_REG_WRITE
  } row_kind_e;

  typedef enum logic [1:0] {
    PICK_LOW,
    PICK_HIGH,
    PICK_ANY
  } pick_e;

  typedef struct {
    row_kind_e                 kind;
    cfg_idx_t                  reg_idx;
    cfg_data_t                 reg_data;
    reading_t                  rd;
    bit                        typed;
    comp_result_t              typed_res;
  } dir_row_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  cfg_idx_t                cfg_idx   = '0;
  cfg_data_t               cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    reading_ok = 1'b0;
  logic signed [14:0]      amb_temp   = '0;
  logic        [13:0]      raw_hum    = '0;
  logic        [16:0]      pres_in    = '0;
  logic signed [14:0]      die_temp   = '0;
  logic                    die_valid  = 1'b0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic signed [14:0]      temp_out;
  logic        [13:0]      hum_out;
  logic        [16:0]      pres_out;
  logic        [10:0]      heat_out;

  // Shadow copy of the register file and the smoothing state.
  logic signed [10:0] cur_room_offset   = -11'sd300;
  logic signed [14:0] cur_die_nominal   = 15'sd3000;
  logic        [7:0]  cur_heat_factor   = 8'd64;
  logic        [10:0] cur_heat_cap      = 11'd250;
  logic        [7:0]  cur_rh_per_degree = 8'd72;
  logic        [8:0]  cur_smooth_alpha  = 9'd51;
  logic        [21:0] hum_avg           = '0;
  bit                 avg_primed        = 1'b0;

  comp_result_t comp_results_q[$];
  dir_row_t     dir_rows[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  bit           no_idle        = 1'b0;

  always #5 clk = ~clk;

  sensor_heat_compensation_ema_unit u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .reading_ok_i        (reading_ok),
    .raw_temperature_i   (amb_temp),
    .raw_humidity_i      (raw_hum),
    .pressure_in_i       (pres_in),
    .die_temperature_i   (die_temp),
    .die_valid_i         (die_valid),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .temperature_out_o   (temp_out),
    .humidity_out_o      (hum_out),
    .pressure_out_o      (pres_out),
    .heat_comp_applied_o (heat_out)
  );

  function automatic void set_register(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      shc_pkg::CFG_ROOM_OFFSET:   cur_room_offset   = data[10:0];
      shc_pkg::CFG_DIE_NOMINAL:   cur_die_nominal   = data[14:0];
      shc_pkg::CFG_HEAT_FACTOR:   cur_heat_factor   = data[7:0];
      shc_pkg::CFG_HEAT_COMP_CAP: cur_heat_cap      = data[10:0];
      shc_pkg::CFG_RH_PER_DEGREE: cur_rh_per_degree = data[7:0];
      shc_pkg::CFG_SMOOTH_ALPHA:  cur_smooth_alpha  = data[8:0];
      default: ;
    endcase
  endfunction

  // Returns 1 and the compensated reading when the sensor read succeeded.
  function automatic bit compensate_reading(input reading_t r, output comp_result_t res);
    longint rt, t, comp, excess, err, h, alpha, hs, avg;
    comp = 0;
    res.temp = '0;
    res.hum  = '0;
    res.pres = '0;
    res.heat = '0;
    if (!r.ok) return 1'b0;
    rt = r.amb_temp;
    t  = rt + cur_room_offset;
    if (r.die_valid) begin
      excess = longint'(r.die_temp) - cur_die_nominal;
      if (excess > 0) begin
        comp = (excess * longint'(cur_heat_factor)) >>> 8;
        if (comp > longint'(cur_heat_cap)) comp = longint'(cur_heat_cap);
      end
      t = t - comp;
      if (t < ClampLow) t = ClampLow;
      else if (t > ClampHigh) t = ClampHigh;
    end else begin
      if (t < SatFloor) t = SatFloor;
      else if (t > SatCeil) t = SatCeil;
    end
    err = rt - t;
    h   = longint'(r.raw_hum) + ((err * longint'(cur_rh_per_degree)) >>> 4);
    if (h < 0) h = 0;
    else if (h > HumCeil) h = HumCeil;
    hs = h << 8;
    if (!avg_primed) begin
      avg        = hs;
      avg_primed = 1'b1;
    end else begin
      avg = longint'(hum_avg);
    end
    alpha   = (cur_smooth_alpha > AlphaFull) ? AlphaFull : longint'(cur_smooth_alpha);
    avg     = ((avg * (AlphaFull - alpha) + hs * alpha) >> 8) & 64'h3FFFFF;
    hum_avg = avg[21:0];
    res.temp = t[14:0];
    res.hum  = avg[21:8];
    res.pres = r.pres;
    res.heat = comp[10:0];
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic reading_t rand_reading();
    reading_t r;
    int       sel;
    r.ok = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 9);
    if (sel == 0) r.amb_temp = 15'($urandom());
    else r.amb_temp = 15'($urandom_range(0, 12500) - 4000);
    sel = $urandom_range(0, 9);
    if (sel == 0) r.raw_hum = 14'($urandom());
    else r.raw_hum = 14'($urandom_range(0, 10000));
    r.pres = 17'($urandom());
    sel = $urandom_range(0, 9);
    // Many die readings sit close to the nominal point, where the cap and zero cases meet.
    if (sel == 0) r.die_temp = 15'($urandom());
    else if (sel < 4) r.die_temp = 15'(int'(cur_die_nominal) + int'($urandom_range(0, 600)) - 100);
    else r.die_temp = 15'($urandom_range(0, 16500) - 4000);
    r.die_valid = ($urandom_range(0, 9) < 7);
    return r;
  endfunction

  function automatic dir_row_t reading_row(bit ok, int rt, int hum, int pres, int die, bit dv);
    dir_row_t row;
    row.kind         = ROW_READING;
    row.reg_idx      = '0;
    row.reg_data     = '0;
    row.rd.ok        = ok;
    row.rd.amb_temp  = 15'(rt);
    row.rd.raw_hum   = 14'(hum);
    row.rd.pres      = 17'(pres);
    row.rd.die_temp  = 15'(die);
    row.rd.die_valid = dv;
    row.typed        = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(int rt, int hum, int pres, int die, bit dv,
                                         int t_exp, int h_exp, int c_exp);
    dir_row_t row;
    row                = reading_row(1'b1, rt, hum, pres, die, dv);
    row.typed          = 1'b1;
    row.typed_res.temp = 15'(t_exp);
    row.typed_res.hum  = 14'(h_exp);
    row.typed_res.pres = 17'(pres);
    row.typed_res.heat = 11'(c_exp);
    return row;
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_t idx, int data);
    dir_row_t row;
    row          = reading_row(1'b0, 0, 0, 0, 0, 1'b0);
    row.kind     = ROW_REG_WRITE;
    row.reg_idx  = idx;
    row.reg_data = cfg_data_t'(data);
    return row;
  endfunction

  task automatic send_reading(input reading_t r, input bit typed,
                              input comp_result_t typed_res);
    comp_result_t res;
    int           gap;
    in_valid   <= 1'b1;
    reading_ok <= r.ok;
    amb_temp   <= r.amb_temp;
    raw_hum    <= r.raw_hum;
    pres_in    <= r.pres;
    die_temp   <= r.die_temp;
    die_valid  <= r.die_valid;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (compensate_reading(r, res)) comp_results_q.push_back(typed ? typed_res : res);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A failed reading leaves nothing in the queue, so give the block time to settle.
  task automatic wait_drained();
    while (comp_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic randomize_config(input pick_e mode);
    int lo, hi, w, v, r;
    for (int i = 0; i < NumRegs; i++) begin
      case (shc_pkg::cfg_idx_e'(i))
        shc_pkg::CFG_ROOM_OFFSET:   begin lo = -1000; hi = 1000;  w = 11; end
        shc_pkg::CFG_DIE_NOMINAL:   begin lo = -4000; hi = 12500; w = 15; end
        shc_pkg::CFG_HEAT_FACTOR:   begin lo = 0;     hi = 255;   w = 8;  end
        shc_pkg::CFG_HEAT_COMP_CAP: begin lo = 0;     hi = 2000;  w = 11; end
        shc_pkg::CFG_RH_PER_DEGREE: begin lo = 0;     hi = 255;   w = 8;  end
        default:                    begin lo = 0;     hi = 256;   w = 9;  end
      endcase
      r = $urandom_range(0, 99);
      if (mode == PICK_LOW || (mode == PICK_ANY && r < 20)) v = lo;
      else if (mode == PICK_HIGH || (mode == PICK_ANY && r < 40)) v = hi;
      else if (r < 55) v = int'($urandom() & ((1 << w) - 1));
      else v = lo + int'($urandom_range(0, hi - lo));
      write_register(cfg_idx_t'(i), cfg_data_t'(v));
    end
    if ($urandom_range(0, 3) == 0) begin
      write_register($urandom_range(0, 1) ? CfgIdxUnmapped : CfgIdxTop,
                     cfg_data_t'($urandom()));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    dir_row_t     row;
    comp_result_t blank_res;
    pick_e        mode;
    bit           writing;

    // Reset defaults; the first good reading loads the average directly.
    dir_rows.push_back(typed_row(2500, 5000, 101325, 0, 1'b0, 2200, 6350, 0));
    dir_rows.push_back(reading_row(1'b0, -16384, 16383, 131071, 16383, 1'b1));
    dir_rows.push_back(reading_row(1'b1, 8500, 10000, 131071, 12500, 1'b1));
    dir_rows.push_back(reading_row(1'b1, -4000, 0, 0, -4000, 1'b1));
    dir_rows.push_back(reading_row(1'b1, -16384, 16383, 0, 0, 1'b0));
    dir_rows.push_back(reading_row(1'b1, 16383, 0, 65536, -16384, 1'b1));
    dir_rows.push_back(reading_row(1'b1, 0, 10000, 1, 16383, 1'b1));
    dir_rows.push_back(reading_row(1'b1, 3000, 4500, 99000, 3000, 1'b1));
    // Full weight on the new sample and no humidity coupling: outputs read off directly.
    dir_rows.push_back(reg_row(shc_pkg::CFG_ROOM_OFFSET, 0));
    dir_rows.push_back(reg_row(shc_pkg::CFG_DIE_NOMINAL, 0));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_FACTOR, 255));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_COMP_CAP, 2000));
    dir_rows.push_back(reg_row(shc_pkg::CFG_RH_PER_DEGREE, 0));
    dir_rows.push_back(reg_row(shc_pkg::CFG_SMOOTH_ALPHA, 256));
    dir_rows.push_back(typed_row(1000, 4000, 12345, 10000, 1'b1, -1000, 4000, 2000));
    dir_rows.push_back(typed_row(-4000, 7777, 54321, 256, 1'b1, -4000, 7777, 255));
    dir_rows.push_back(typed_row(-16384, 16383, 0, 0, 1'b0, -16384, 10000, 0));
    dir_rows.push_back(typed_row(9000, 2500, 70000, -100, 1'b1, 8500, 2500, 0));
    dir_rows.push_back(typed_row(16383, 0, 131071, 12500, 1'b0, 16383, 0, 0));
    // Average frozen, strongest coupling, no self-heating term.
    dir_rows.push_back(reg_row(shc_pkg::CFG_ROOM_OFFSET, -1000));
    dir_rows.push_back(reg_row(shc_pkg::CFG_DIE_NOMINAL, 12500));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_FACTOR, 0));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_COMP_CAP, 0));
    dir_rows.push_back(reg_row(shc_pkg::CFG_RH_PER_DEGREE, 255));
    dir_rows.push_back(reg_row(shc_pkg::CFG_SMOOTH_ALPHA, 0));
    dir_rows.push_back(reading_row(1'b1, -4000, 100, 4242, 12500, 1'b1));
    dir_rows.push_back(reading_row(1'b1, 8500, 9000, 100000, -4000, 1'b0));
    // Alpha beyond full scale, plus writes outside the register map.
    dir_rows.push_back(reg_row(shc_pkg::CFG_ROOM_OFFSET, 1000));
    dir_rows.push_back(reg_row(shc_pkg::CFG_DIE_NOMINAL, -4000));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_FACTOR, 128));
    dir_rows.push_back(reg_row(shc_pkg::CFG_HEAT_COMP_CAP, 1000));
    dir_rows.push_back(reg_row(shc_pkg::CFG_SMOOTH_ALPHA, 511));
    dir_rows.push_back(reg_row(CfgIdxUnmapped, 1234));
    dir_rows.push_back(reg_row(CfgIdxTop, 32767));
    dir_rows.push_back(reading_row(1'b1, -4000, 50, 1, -4000, 1'b1));
    dir_rows.push_back(reading_row(1'b1, 8500, 5000, 77777, 12500, 1'b1));
    dir_rows.push_back(reading_row(1'b1, -1000, 5000, 2, 16383, 1'b1));
    dir_rows.push_back(reading_row(1'b0, 1234, 4321, 555, 2222, 1'b0));
    dir_rows.push_back(reading_row(1'b1, 5000, 10000, 131071, -16384, 1'b0));

    blank_res = dir_rows[0].typed_res;
    writing   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG_WRITE) begin
        if (!writing) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        writing = 1'b1;
        write_register(row.reg_idx, row.reg_data);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_reading(row.rd, row.typed, row.typed_res);
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      if (p == 0) mode = PICK_LOW;
      else if (p == 1) mode = PICK_HIGH;
      else mode = PICK_ANY;
      randomize_config(mode);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (ReadingsPerPhase) send_reading(rand_reading(), 1'b0, blank_res);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  // Handshake signals only move at the rising edge, so the falling edge sees each beat.
  always @(negedge clk) begin
    comp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (comp_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result beat: temp %0d hum %0d pres %0d heat %0d",
                   temp_out, hum_out, pres_out, heat_out);
        end
      end else begin
        want = comp_results_q.pop_front();
        if (temp_out !== want.temp || hum_out !== want.hum ||
            pres_out !== want.pres || heat_out !== want.heat) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("mismatch: temp %0d/%0d hum %0d/%0d pres %0d/%0d heat %0d/%0d",
                     want.temp, temp_out, want.hum, hum_out,
                     want.pres, pres_out, want.heat, heat_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout with %0d results outstanding", comp_results_q.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule
